### hdl/w26tx_pkg.sv
// Shared types and constants for the Wiegand 26-bit frame transmitter.
// Used by the top level and by its port checker; depends on nothing.
package w26tx_pkg;

    // Configuration register indexes and widths
    localparam int CFG_W       = 16;
    localparam int CFG_ADDR_W  = 1;
    localparam logic [CFG_ADDR_W-1:0] REG_PULSE_TICKS = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_GAP_TICKS   = 1'b1;
    localparam logic [CFG_W-1:0] PULSE_TICKS_RST = 16'd100;
    localparam logic [CFG_W-1:0] GAP_TICKS_RST   = 16'd1000;

    // Frame geometry
    localparam int FRAME_BITS = 26;
    localparam int CARD_W     = 24;
    localparam int HALF_W     = 12;
    localparam int BITS_LEFT_W = 5;

    // Input kinds carried on s_tuser
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_SEND = 1'b1;

    // Result tdata layout, lowest bit up
    localparam int OUT_DATA_W   = 8;
    localparam int OUT_DATA_BIT = 0;
    localparam int OUT_STB_BIT  = 1;
    localparam int OUT_BUSY_BIT = 2;
    localparam int OUT_IGN_BIT  = 3;
    localparam int OUT_DONE_BIT = 4;

endpackage

### hdl/wiegand26_frame_transmitter.sv
// Wiegand 26-bit frame transmitter: one result per accepted tick/send item.
// Result is registered; throughput one item per cycle unless m_tready stalls it.
// Timing state and frame shift register update at the input transfer; the result
// sits in an output register, and a new item is taken whenever that register is
// empty or drained in the same cycle. Synchronous active-low reset: idle phase,
// data low, strobe high, registers at 100 / 1000 ticks, no result pending.
// Depends on w26tx_pkg.
module wiegand26_frame_transmitter #(
    parameter int TIMER_WIDTH = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration write port
    input  logic                                cfg_wr_en,
    input  logic [w26tx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [w26tx_pkg::CFG_W-1:0]         cfg_wdata,
    // input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [23:0]                         s_tdata,  // [23:0] card_value
    input  logic                                s_tuser,  // [0] op
    // result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] data_line, [1] strobe_n, [2] busy_res, [3] send_ignored, [4] frame_done
    output logic [w26tx_pkg::OUT_DATA_W-1:0]    m_tdata
);

    localparam int CW = (TIMER_WIDTH > w26tx_pkg::CFG_W) ? TIMER_WIDTH : w26tx_pkg::CFG_W;
    localparam logic [CW-1:0] TMAX_W = CW'({TIMER_WIDTH{1'b1}});
    localparam logic [TIMER_WIDTH-1:0] TMAX_T = {TIMER_WIDTH{1'b1}};
    localparam int FB = w26tx_pkg::FRAME_BITS;
    localparam int BW = w26tx_pkg::BITS_LEFT_W;

    typedef enum logic [1:0] {PH_IDLE, PH_LEAD, PH_BITS, PH_TAIL} phase_t;

    // configuration registers
    logic [w26tx_pkg::CFG_W-1:0] pulse_reg, gap_reg;

    // frame state
    phase_t                 phase_reg, phase_next;
    logic [FB-1:0]          shift_reg, shift_next;
    logic [BW-1:0]          bits_left_reg, bits_left_next;
    logic [TIMER_WIDTH-1:0] tick_reg, tick_next;
    logic                   data_reg, data_next;
    logic                   strobe_reg, strobe_next;

    // result register
    logic                   m_valid_reg;
    logic [w26tx_pkg::OUT_DATA_W-1:0] m_data_reg, m_data_next;

    logic                   ignored, done, s_accept;
    logic [CW-1:0]          gap_ext, pulse_ext, gap_clip, pulse_clip;
    logic [TIMER_WIDTH-1:0] gap_t, pulse_t, tick_inc;
    logic [w26tx_pkg::CARD_W-1:0] card;
    logic                   lead_par, trail_par;

    assign s_tready = !m_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign card     = s_tdata;

    // clip timing registers to the counter range; a zero gap acts as one tick
    always_comb begin
        gap_ext   = CW'(gap_reg);
        pulse_ext = CW'(pulse_reg);
        if (gap_ext == '0) begin
            gap_ext = CW'(1);
        end
        gap_clip   = (gap_ext > TMAX_W) ? TMAX_W : gap_ext;
        pulse_clip = (pulse_ext > TMAX_W) ? TMAX_W : pulse_ext;
        if (pulse_clip > gap_clip) begin
            pulse_clip = gap_clip;
        end
        gap_t   = gap_clip[TIMER_WIDTH-1:0];
        pulse_t = pulse_clip[TIMER_WIDTH-1:0];
    end

    // frame parity: even over the upper half, odd over the lower half
    assign lead_par  = ^card[w26tx_pkg::CARD_W-1:w26tx_pkg::HALF_W];
    assign trail_par = ~^card[w26tx_pkg::HALF_W-1:0];

    assign tick_inc = (tick_reg == TMAX_T) ? tick_reg : tick_reg + 1'b1;

    // next state for one item
    always_comb begin
        phase_next     = phase_reg;
        shift_next     = shift_reg;
        bits_left_next = bits_left_reg;
        tick_next      = tick_reg;
        data_next      = data_reg;
        strobe_next    = strobe_reg;
        ignored        = 1'b0;
        done           = 1'b0;
        if (s_tuser == w26tx_pkg::OP_SEND) begin
            if (phase_reg != PH_IDLE) begin
                ignored = 1'b1;
            end else begin
                shift_next     = {lead_par, card, trail_par};
                bits_left_next = BW'(FB);
                tick_next      = '0;
                phase_next     = PH_LEAD;
                strobe_next    = 1'b1;
            end
        end else if (phase_reg != PH_IDLE) begin
            tick_next = tick_inc;
            // release the strobe once the pulse time has run
            if ((phase_reg == PH_BITS || phase_reg == PH_TAIL) && tick_inc >= pulse_t) begin
                strobe_next = 1'b1;
            end
            // gap elapsed: start the next bit or finish the frame
            if (tick_inc >= gap_t) begin
                tick_next = '0;
                if (phase_reg == PH_TAIL || bits_left_reg == '0) begin
                    phase_next  = PH_IDLE;
                    strobe_next = 1'b1;
                    done        = 1'b1;
                end else begin
                    data_next      = shift_reg[FB-1];
                    shift_next     = {shift_reg[FB-2:0], 1'b0};
                    bits_left_next = bits_left_reg - 1'b1;
                    strobe_next    = 1'b0;
                    phase_next     = (bits_left_reg == BW'(1)) ? PH_TAIL : PH_BITS;
                end
            end
        end
    end

    // pack the result word
    always_comb begin
        m_data_next = '0;
        m_data_next[w26tx_pkg::OUT_DATA_BIT] = data_next;
        m_data_next[w26tx_pkg::OUT_STB_BIT]  = strobe_next;
        m_data_next[w26tx_pkg::OUT_BUSY_BIT] = (phase_next != PH_IDLE);
        m_data_next[w26tx_pkg::OUT_IGN_BIT]  = ignored;
        m_data_next[w26tx_pkg::OUT_DONE_BIT] = done;
    end

    // state, configuration and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_reg     <= w26tx_pkg::PULSE_TICKS_RST;
            gap_reg       <= w26tx_pkg::GAP_TICKS_RST;
            phase_reg     <= PH_IDLE;
            shift_reg     <= '0;
            bits_left_reg <= '0;
            tick_reg      <= '0;
            data_reg      <= 1'b0;
            strobe_reg    <= 1'b1;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    w26tx_pkg::REG_PULSE_TICKS: pulse_reg <= cfg_wdata;
                    w26tx_pkg::REG_GAP_TICKS:   gap_reg   <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_accept) begin
                phase_reg     <= phase_next;
                shift_reg     <= shift_next;
                bits_left_reg <= bits_left_next;
                tick_reg      <= tick_next;
                data_reg      <= data_next;
                strobe_reg    <= strobe_next;
                m_valid_reg   <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg   <= 1'b0;
            end
        end
        // result payload, no reset
        if (s_accept) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule

### hdl/w26tx_checker.sv
// Port-level checker for the Wiegand 26-bit frame transmitter, bound to the top.
// Depends on w26tx_pkg for the result field layout.
module w26tx_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tready,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [w26tx_pkg::OUT_DATA_W-1:0]    m_tdata
);

    logic r_stb, r_busy, r_ign, r_done;
    assign r_stb  = m_tdata[w26tx_pkg::OUT_STB_BIT];
    assign r_busy = m_tdata[w26tx_pkg::OUT_BUSY_BIT];
    assign r_ign  = m_tdata[w26tx_pkg::OUT_IGN_BIT];
    assign r_done = m_tdata[w26tx_pkg::OUT_DONE_BIT];

    // a finished frame leaves the block idle
    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_done) |-> !r_busy)
        else $error("frame_done reported while still busy");

    // an ignored send only happens while a frame is in progress
    a_ign_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && r_ign) |-> (r_busy && !r_done))
        else $error("send_ignored reported outside a busy frame");

    // strobe is inactive whenever the block is idle
    a_idle_strobe: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !r_busy) |-> r_stb)
        else $error("strobe_n low while idle");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // an empty result register never blocks the input
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with no result pending");

endmodule

bind wiegand26_frame_transmitter w26tx_checker u_w26tx_checker (.*);
